[hdl/assert_macros.svh]
// Shared assertion macros. All checks are clocked on the rising edge and
// are switched off while the asynchronous reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define ASSERT_PROP(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");

// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

[hdl/npc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

	localparam int CHANNEL_BITS        = 10;
	localparam int COLOR_BITS          = 3 * CHANNEL_BITS;
	localparam int SQ_BITS             = 2 * CHANNEL_BITS;
	localparam int DIST_BITS           = SQ_BITS + 2;
	localparam int INDEX_BITS          = 5;
	localparam int SIZE_BITS           = 6;
	localparam int PALETTE_ENTRIES_DEF = 32;

	localparam logic [SIZE_BITS-1:0] PALETTE_SIZE_RESET = SIZE_BITS'(32);

	typedef enum logic {
		CMD_LOAD     = 1'b0,
		CMD_CLASSIFY = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                  command;
		logic [INDEX_BITS-1:0] entry_index;
		logic [COLOR_BITS-1:0] entry_color;
		logic [COLOR_BITS-1:0] pixel_color;
	} npc_in_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] nearest_index;
		logic [DIST_BITS-1:0]  nearest_distance;
	} npc_out_t;

endpackage

`default_nettype wire

[hdl/npc_dist.sv]
`timescale 1ns / 1ps
`default_nettype none

// Squared distance between a pixel and one palette entry, two stages:
// per-channel square, then the three-way sum.
module npc_dist (
	input  wire logic                           clk,
	input  wire logic [npc_pkg::COLOR_BITS-1:0] pixel,
	input  wire logic [npc_pkg::COLOR_BITS-1:0] entry,
	output logic      [npc_pkg::DIST_BITS-1:0]  dist_s3
);

	localparam int CB = npc_pkg::CHANNEL_BITS;
	localparam int SB = npc_pkg::SQ_BITS;
	localparam int DB = npc_pkg::DIST_BITS;

	logic [SB-1:0] sq_s2 [3];

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [CB-1:0] a;
		logic [CB-1:0] b;
		logic [CB-1:0] diff;

		assign a    = pixel[c*CB +: CB];
		assign b    = entry[c*CB +: CB];
		assign diff = (a >= b) ? (a - b) : (b - a);

		always_ff @(posedge clk) begin
			sq_s2[c] <= SB'(diff) * SB'(diff);
		end
	end

	always_ff @(posedge clk) begin
		dist_s3 <= DB'(sq_s2[0]) + DB'(sq_s2[1]) + DB'(sq_s2[2]);
	end

endmodule

`default_nettype wire

[hdl/npc_min_tree.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Registered binary minimum tree, one level per stage. Leaves are padded to
// a power of two; a disabled leaf never wins over an enabled one. On equal
// distances the left (lower index) child is kept.
module npc_min_tree #(
	parameter int LEAVES = npc_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic [LEAVES-1:0]               leaf_en,
	input  wire logic [npc_pkg::DIST_BITS-1:0]   leaf_dist [LEAVES],
	output logic                                 out_valid,
	output logic      [$clog2(LEAVES)-1:0]       out_index,
	output logic      [npc_pkg::DIST_BITS-1:0]   out_dist
);

	localparam int LEVELS = $clog2(LEAVES);
	localparam int N      = 1 << LEVELS;
	localparam int IW     = LEVELS;
	localparam int DW     = npc_pkg::DIST_BITS;

	logic [DW-1:0] pad_dist [N];
	logic [N-1:0]  pad_en;

	logic [DW-1:0] node_dist_q [1:N-1];
	logic [IW-1:0] node_idx_q  [1:N-1];
	logic [N-1:1]  node_en_q;
	logic [LEVELS-1:0] vld_q;

	for (genvar j = 0; j < N; j++) begin : g_pad
		if (j < LEAVES) begin : g_used
			assign pad_dist[j] = leaf_dist[j];
			assign pad_en[j]   = leaf_en[j];
		end else begin : g_empty
			assign pad_dist[j] = '0;
			assign pad_en[j]   = 1'b0;
		end
	end

	// heap layout: node i has children 2i and 2i+1, leaves sit at N..2N-1
	for (genvar i = 1; i < N; i++) begin : g_node
		logic [DW-1:0] ld;
		logic [DW-1:0] rd;
		logic [IW-1:0] li;
		logic [IW-1:0] ri;
		logic          le;
		logic          re;
		logic          take_r;

		if (2 * i >= N) begin : g_bottom
			assign ld = pad_dist[2*i-N];
			assign rd = pad_dist[2*i+1-N];
			assign li = IW'(2*i-N);
			assign ri = IW'(2*i+1-N);
			assign le = pad_en[2*i-N];
			assign re = pad_en[2*i+1-N];
		end else begin : g_inner
			assign ld = node_dist_q[2*i];
			assign rd = node_dist_q[2*i+1];
			assign li = node_idx_q[2*i];
			assign ri = node_idx_q[2*i+1];
			assign le = node_en_q[2*i];
			assign re = node_en_q[2*i+1];
		end

		// strictly smaller wins, so ties keep the lower index
		assign take_r = re && (!le || (rd < ld));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				node_en_q[i] <= 1'b0;
			end else begin
				node_en_q[i] <= le | re;
			end
		end

		always_ff @(posedge clk) begin
			node_dist_q[i] <= take_r ? rd : ld;
			node_idx_q[i]  <= take_r ? ri : li;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= LEVELS'({vld_q, in_valid});
		end
	end

	assign out_valid = vld_q[LEVELS-1];
	assign out_index = node_idx_q[1];
	assign out_dist  = node_dist_q[1];

	// the winner can never be farther than leaf zero when leaf zero took part
	`ASSERT_IMPLIES(a_min_not_above_leaf0, clk, arst_n,
		out_valid && $past(leaf_en[0], LEVELS),
		out_dist <= $past(leaf_dist[0], LEVELS))

endmodule

`default_nettype wire

[hdl/nearest_palette_color.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Nearest palette color by squared Euclidean distance over Y/Cb/Cr.
//
// Command channel: a transaction is taken on a rising edge with start high
// and busy low. busy stays low, so one transaction per cycle is taken.
// A load writes palette entry entry_index with entry_color (indexes past the
// palette depth are dropped) and returns nothing. A classify returns one
// result: the index of the closest entry among the first N entries, N being
// the configured search size (zero counts as one), and its distance; ties go
// to the lower index.
// Config channel: cfg_data is the search size, written on cfg_valid with
// cfg_ready, which is always high. Write it only while nothing is in flight.
// A classify result is strobed on result_valid for one cycle. Its path runs
// through the input register, square stage, sum stage, then one level of the
// minimum tree per stage. One result per cycle sustained.
// A load is visible to any classify taken on a later edge.
// The result side cannot stall; results are always presented and dropped
// after their cycle. Reset clears all palette entries to zero, sets the
// search size to 32 and empties the pipeline.
module nearest_palette_color #(
	parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire npc_pkg::npc_in_t              request,
	output logic                               result_valid,
	output npc_pkg::npc_out_t                  result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [npc_pkg::SIZE_BITS-1:0] cfg_data
);

	localparam int IDX_W   = $clog2(PALETTE_ENTRIES);
	localparam int LATENCY = IDX_W + 3;
	localparam int CW      = npc_pkg::COLOR_BITS;
	localparam int DW      = npc_pkg::DIST_BITS;

	logic                          accept;
	logic                          load_ok;
	logic [IDX_W-1:0]              widx;
	logic [CW-1:0]                 palette_q [PALETTE_ENTRIES];
	logic [npc_pkg::SIZE_BITS-1:0] search_size_q;

	logic [CW-1:0]                 pixel_s1;
	logic                          cls_s1;
	logic                          cls_s2;
	logic                          cls_s3;
	logic [DW-1:0]                 dist_s3 [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0]    leaf_en;

	logic                          tree_valid;
	logic [IDX_W-1:0]              tree_index;
	logic [DW-1:0]                 tree_dist;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign widx      = IDX_W'(request.entry_index);
	assign load_ok   = accept && (request.command == npc_pkg::CMD_LOAD)
		&& (32'(request.entry_index) < PALETTE_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_size_q <= npc_pkg::PALETTE_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			search_size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PALETTE_ENTRIES; k++) begin
				palette_q[k] <= '0;
			end
		end else if (load_ok) begin
			palette_q[widx] <= request.entry_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_s1 <= 1'b0;
			cls_s2 <= 1'b0;
			cls_s3 <= 1'b0;
		end else begin
			cls_s1 <= accept && (request.command == npc_pkg::CMD_CLASSIFY);
			cls_s2 <= cls_s1;
			cls_s3 <= cls_s2;
		end
	end

	always_ff @(posedge clk) begin
		pixel_s1 <= request.pixel_color;
	end

	// size zero still searches entry zero; sizes past the depth search all
	for (genvar j = 0; j < PALETTE_ENTRIES; j++) begin : g_entry
		assign leaf_en[j] = (j == 0) || (32'(search_size_q) > j);

		npc_dist u_dist (
			.clk     (clk),
			.pixel   (pixel_s1),
			.entry   (palette_q[j]),
			.dist_s3 (dist_s3[j])
		);
	end

	npc_min_tree #(
		.LEAVES (PALETTE_ENTRIES)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cls_s3),
		.leaf_en   (leaf_en),
		.leaf_dist (dist_s3),
		.out_valid (tree_valid),
		.out_index (tree_index),
		.out_dist  (tree_dist)
	);

	assign result_valid            = tree_valid;
	assign result.nearest_index    = npc_pkg::INDEX_BITS'(tree_index);
	assign result.nearest_distance = tree_dist;

	`ASSERT_IMPLIES(a_result_has_cause, clk, arst_n, result_valid,
		$past(accept && (request.command == npc_pkg::CMD_CLASSIFY), LATENCY))
	`ASSERT_IMPLIES(a_classify_answered, clk, arst_n,
		accept && (request.command == npc_pkg::CMD_CLASSIFY), ##LATENCY result_valid)
	`ASSERT_NEXT(a_load_lands, clk, arst_n, load_ok,
		palette_q[$past(widx)] == $past(request.entry_color))

endmodule

`default_nettype wire

[dv/nearest_color_checker.sv]
`timescale 1ns / 1ps

module nearest_color_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  npc_pkg::npc_in_t              request,
	input  logic                          result_valid,
	input  npc_pkg::npc_out_t             result,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [npc_pkg::SIZE_BITS-1:0] cfg_data,
	output int                            mismatches,
	output int                            pending
);
	import npc_pkg::*;

	localparam int ENTRIES   = PALETTE_ENTRIES_DEF;
	localparam int PRINT_CAP = 200;

	logic [COLOR_BITS-1:0] palette_mem [ENTRIES];
	logic [SIZE_BITS-1:0]  search_size;
	npc_out_t              expected_matches [$];

	function automatic logic [SQ_BITS-1:0] channel_sq(input logic [CHANNEL_BITS-1:0] a,
		input logic [CHANNEL_BITS-1:0] b);
		logic [CHANNEL_BITS-1:0] d;
		d = (a >= b) ? a - b : b - a;
		return SQ_BITS'(d) * SQ_BITS'(d);
	endfunction

	function automatic logic [DIST_BITS-1:0] color_distance(input logic [COLOR_BITS-1:0] a,
		input logic [COLOR_BITS-1:0] b);
		logic [DIST_BITS-1:0] sum;
		int c;
		sum = '0;
		for (c = 0; c < 3; c++) begin
			sum += DIST_BITS'(channel_sq(a[c*CHANNEL_BITS +: CHANNEL_BITS],
				b[c*CHANNEL_BITS +: CHANNEL_BITS]));
		end
		return sum;
	endfunction

	// strict compare, so the lowest index keeps a tie
	function automatic npc_out_t closest_entry(input logic [COLOR_BITS-1:0] pixel);
		npc_out_t             best;
		logic [DIST_BITS-1:0] d;
		int                   count;
		int                   j;
		if (search_size == 0)
			count = 1;
		else if (search_size > ENTRIES)
			count = ENTRIES;
		else
			count = int'(search_size);
		best.nearest_index    = '0;
		best.nearest_distance = color_distance(pixel, palette_mem[0]);
		for (j = 1; j < count; j++) begin
			d = color_distance(pixel, palette_mem[j]);
			if (d < best.nearest_distance) begin
				best.nearest_distance = d;
				best.nearest_index    = INDEX_BITS'(j);
			end
		end
		return best;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("%0t ns: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		npc_out_t want;
		int       i;
		if (!arst_n) begin
			for (i = 0; i < ENTRIES; i++)
				palette_mem[i] = '0;
			search_size = PALETTE_SIZE_RESET;
			expected_matches.delete();
			pending = 0;
		end else begin
			if (result_valid) begin
				if (expected_matches.size() == 0) begin
					report_mismatch($sformatf("result with no classify pending: index %0d distance %0d",
						result.nearest_index, result.nearest_distance));
				end else begin
					want = expected_matches.pop_front();
					if (result.nearest_index !== want.nearest_index)
						report_mismatch($sformatf("nearest_index %0d, expected %0d",
							result.nearest_index, want.nearest_index));
					if (result.nearest_distance !== want.nearest_distance)
						report_mismatch($sformatf("nearest_distance %0d, expected %0d",
							result.nearest_distance, want.nearest_distance));
				end
			end
			if (cfg_valid && cfg_ready)
				search_size = cfg_data;
			if (start && !busy) begin
				if (request.command == CMD_LOAD)
					palette_mem[request.entry_index] = request.entry_color;
				else
					expected_matches.push_back(closest_entry(request.pixel_color));
			end
			pending = expected_matches.size();
		end
	end

endmodule

[dv/tb_nearest_palette_color.sv]
`timescale 1ns / 1ps

module tb_nearest_palette_color;
	import npc_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 16;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int ENTRIES         = PALETTE_ENTRIES_DEF;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	npc_in_t              request   = '0;
	logic                 cfg_valid = 1'b0;
	logic [SIZE_BITS-1:0] cfg_data  = '0;
	logic                 busy;
	logic                 result_valid;
	npc_out_t             result;
	logic                 cfg_ready;

	int mismatches;
	int pending;
	int clk_ticks = 0;
	bit idling_on = 1'b1;

	// colors loaded so far, used to aim pixels near palette entries
	logic [COLOR_BITS-1:0] palette_copy [ENTRIES];

	nearest_palette_color DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.result_valid(result_valid),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	nearest_color_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.result_valid(result_valid),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		clk_ticks <= clk_ticks + 1;
		if (clk_ticks >= CYCLE_LIMIT) begin
			$display("nearest_palette_color verification failed");
			$finish;
		end
	end

	function automatic logic [CHANNEL_BITS-1:0] pick_channel();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return CHANNEL_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [COLOR_BITS-1:0] pick_color();
		return {pick_channel(), pick_channel(), pick_channel()};
	endfunction

	// move each channel by up to 3 steps, clamped to the channel range
	function automatic logic [COLOR_BITS-1:0] nudge_color(input logic [COLOR_BITS-1:0] base);
		logic [COLOR_BITS-1:0] moved;
		int                    c;
		int                    v;
		for (c = 0; c < 3; c++) begin
			v = int'(base[c*CHANNEL_BITS +: CHANNEL_BITS]) + int'($urandom_range(0, 6)) - 3;
			if (v < 0)
				v = 0;
			if (v > (1 << CHANNEL_BITS) - 1)
				v = (1 << CHANNEL_BITS) - 1;
			moved[c*CHANNEL_BITS +: CHANNEL_BITS] = CHANNEL_BITS'(v);
		end
		return moved;
	endfunction

	task automatic send(input npc_in_t item);
		int n;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 7);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
		start   <= 1'b1;
		request <= item;
		do @(posedge clk); while (busy);
		if (item.command == CMD_LOAD)
			palette_copy[item.entry_index] = item.entry_color;
	endtask

	task automatic load_entry(input int idx, input logic [COLOR_BITS-1:0] color);
		npc_in_t item;
		item.command     = CMD_LOAD;
		item.entry_index = INDEX_BITS'(idx);
		item.entry_color = color;
		item.pixel_color = COLOR_BITS'($urandom);
		send(item);
	endtask

	task automatic classify(input logic [COLOR_BITS-1:0] pixel);
		npc_in_t item;
		item.command     = CMD_CLASSIFY;
		item.entry_index = INDEX_BITS'($urandom);
		item.entry_color = COLOR_BITS'($urandom);
		item.pixel_color = pixel;
		send(item);
	endtask

	// drop start, let every pending classify come back, then let the pipe drain
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		int                    i;
		int                    idx;
		int                    pick;
		logic [COLOR_BITS-1:0] color;
		for (i = 0; i < count; i++) begin
			idx  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 31);
			pick = $urandom_range(0, 9);
			if ($urandom_range(0, 9) < 3) begin
				if (pick < 5)
					color = pick_color();
				else if (pick < 8)
					color = nudge_color(palette_copy[$urandom_range(0, ENTRIES - 1)]);
				else
					color = COLOR_BITS'($urandom);
				load_entry(idx, color);
			end else begin
				if (pick < 4)
					color = nudge_color(palette_copy[idx]);
				else if (pick < 6)
					color = palette_copy[idx];
				else if (pick < 8)
					color = pick_color();
				else
					color = COLOR_BITS'($urandom);
				classify(color);
			end
		end
	endtask

	initial begin
		logic [SIZE_BITS-1:0] sizes [8];
		int                   p;
		int                   i;
		sizes = '{6'd1, 6'd0, 6'd63, 6'd33, 6'd2, 6'd17, 6'd32, 6'd0};
		sizes[7] = SIZE_BITS'($urandom_range(3, 31));
		for (i = 0; i < ENTRIES; i++)
			palette_copy[i] = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cleared palette: every entry ties, index zero must win
		classify('0);
		classify('1);
		load_entry(0, '1);
		load_entry(31, '0);
		classify('1);
		classify('0);
		classify({10'd0, 10'd1023, 10'd0});
		load_entry(5, {10'd512, 10'd512, 10'd512});
		load_entry(9, {10'd512, 10'd512, 10'd512});
		classify({10'd510, 10'd514, 10'd511});
		load_entry(1, {10'd1023, 10'd0, 10'd0});
		load_entry(2, {10'd0, 10'd1023, 10'd0});
		load_entry(3, {10'd0, 10'd0, 10'd1023});
		classify({10'd1023, 10'd0, 10'd0});
		classify({10'd0, 10'd1023, 10'd1});
		classify({10'd2, 10'd0, 10'd1023});
		load_entry(31, {10'd100, 10'd200, 10'd300});
		classify({10'd100, 10'd200, 10'd300});
		load_entry(0, '0);
		classify({10'd0, 10'd0, 10'd1023});
		classify('1);
		settle();

		for (p = 0; p < 8; p++) begin
			if (p == 7)
				idling_on = 1'b0;
			write_size(sizes[p]);
			random_phase(ITEMS_PER_PHASE);
			settle();
		end

		if (mismatches == 0)
			$display("nearest_palette_color verification clean");
		else
			$display("nearest_palette_color verification failed");
		$finish;
	end

endmodule
